/* design/ssdr_pkg.sv */
// Shared types and constants for the descending-rank set block.
// Holds the command and status codes and the result record; depends on nothing.
package ssdr_pkg;

  localparam int STATUS_W = 3;
  localparam int RANK_W   = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [RANK_W-1:0]   rank;
  } res_t;

endpackage

/* design/ssdr_core.sv */
// Value table and scan engine for the descending-rank set block.
// Uses ssdr_pkg for codes and the result record.
module ssdr_core #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   cmd,
  input  logic [VALUE_WIDTH-1:0] key,
  output logic                   busy,
  output logic                   res_valid,
  input  logic                   res_take,
  output ssdr_pkg::res_t         res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                 state;
  logic                   cmd_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [CW-1:0]          issued;
  logic                   rd_pending;
  logic [CW-1:0]          ge;
  logic                   present;
  logic [CW-1:0]          entry_count;
  ssdr_pkg::res_t         res_q;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [IW-1:0]          rd_addr;
  logic                   issue;
  logic                   mem_we;
  logic [CW+ssdr_pkg::RANK_W-1:0] ge_ext;

  assign issue   = (state == S_SCAN) && (issued != entry_count);
  assign rd_addr = issued[IW-1:0];
  assign mem_we  = (state == S_FINISH) && (cmd_q == ssdr_pkg::CMD_INSERT) && !present &&
                   (entry_count != CAP_C);
  assign ge_ext  = {{ssdr_pkg::RANK_W{1'b0}}, ge};

  // Reads happen only while scanning and the single write only in the finish
  // state, so a read and a write never touch the table in the same cycle.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[entry_count[IW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_pending  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q      <= cmd;
            key_q      <= key;
            issued     <= '0;
            ge         <= '0;
            present    <= 1'b0;
            rd_pending <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            issued <= issued + 1'b1;
          end
          rd_pending <= issue;
          if (rd_pending) begin
            if (rd_data == key_q) begin
              present <= 1'b1;
            end
            if ($signed(rd_data) >= $signed(key_q)) begin
              ge <= ge + 1'b1;
            end
          end
          // Leave once every entry was read and the last datum was counted.
          if (!issue && !rd_pending) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          res_q.rank <= '0;
          if (cmd_q == ssdr_pkg::CMD_INSERT) begin
            if (present) begin
              res_q.status <= ssdr_pkg::ST_DUPLICATE;
            end else if (entry_count == CAP_C) begin
              res_q.status <= ssdr_pkg::ST_FULL;
            end else begin
              res_q.status <= ssdr_pkg::ST_INSERTED;
              entry_count  <= entry_count + 1'b1;
            end
          end else begin
            if (present) begin
              res_q.status <= ssdr_pkg::ST_FOUND;
              res_q.rank   <= ge_ext[ssdr_pkg::RANK_W-1:0];
            end else begin
              res_q.status <= ssdr_pkg::ST_NOT_FOUND;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

endmodule

/* design/sorted_set_descending_rank_unit.sv */
// Top level of the descending-rank set block: input handshake and output register.
// Depends on ssdr_pkg and ssdr_core.
//
// The block keeps a set of distinct signed values in a one-port table of
// CAPACITY entries. Each transfer on the input channel (in_valid, in_stall,
// command, value) is an insert (command 0) or a rank query (command 1), and
// each gives exactly one transfer on the output channel (out_valid, out_stall,
// status, rank). A query returns the count of stored values greater than or
// equal to the value, or not found.
// Every command reads all stored entries from the table, one per cycle, before
// its result is formed and the block can take the next input transfer.
// One item is worked on at a time; in_stall is high while it is in progress.
// The finished result moves into the output register, so the next item can be
// taken while a result still waits behind a stalled receiver; a second result
// waits in the engine until the output register frees up.
// Synchronous reset empties the set and drops any result in flight; no
// clearing pass is needed.
module sorted_set_descending_rank_unit #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [VALUE_WIDTH-1:0]        value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssdr_pkg::STATUS_W-1:0] status,
  output logic [ssdr_pkg::RANK_W-1:0]   rank
);

  logic           start;
  logic           busy;
  logic           res_valid;
  logic           res_take;
  ssdr_pkg::res_t res;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign res_take = res_valid && (!out_valid || !out_stall);

  ssdr_core #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (command),
    .key       (value),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status <= res.status;
      rank   <= res.rank;
    end
  end

  // An accepted item keeps the input side closed on the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command was still in progress");

  // Only a found query carries a rank.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ssdr_pkg::ST_FOUND) |-> rank == '0)
    else $error("nonzero rank on a result that is not a found query");

  // A found value counts at least itself.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ssdr_pkg::ST_FOUND) && (CAPACITY < 128) |-> rank != '0)
    else $error("found query reported a zero rank");

  // A result moves to the output register only when that register can take it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(rank))
    else $error("output register overwritten while the receiver stalled");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_set_descending_rank_unit.
// Sends inserts and rank queries with random idling on both channels and checks each
// result against a behavioral set model. Depends on ssdr_pkg and the block's RTL.
module testbench;

  localparam int CAPACITY     = 64;
  localparam int VALUE_WIDTH  = 32;
  localparam int RANDOM_ITEMS = 1250;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_LEN = 23;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  typedef struct {
    logic                        cmd;
    val_t                        val;
    bit                          known;
    ssdr_pkg::status_t           st;
    logic [ssdr_pkg::RANK_W-1:0] rk;
  } stim_row_t;

  // Rows marked known carry the result that follows directly from the set contents.
  stim_row_t directed_rows [DIRECTED_LEN] = '{
    '{ssdr_pkg::CMD_QUERY,  32'h0000_0000, 1'b1, ssdr_pkg::ST_NOT_FOUND, 7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, ssdr_pkg::ST_DUPLICATE, 7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b1, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'h7FFF_FFFF, 1'b1, ssdr_pkg::ST_FOUND,     7'd1},
    '{ssdr_pkg::CMD_QUERY,  32'h8000_0000, 1'b1, ssdr_pkg::ST_FOUND,     7'd2},
    '{ssdr_pkg::CMD_QUERY,  32'h0000_0000, 1'b1, ssdr_pkg::ST_NOT_FOUND, 7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'hFFFF_FFFF, 1'b1, ssdr_pkg::ST_FOUND,     7'd3},
    '{ssdr_pkg::CMD_QUERY,  32'h0000_0000, 1'b1, ssdr_pkg::ST_FOUND,     7'd2},
    '{ssdr_pkg::CMD_QUERY,  32'h0000_0001, 1'b1, ssdr_pkg::ST_NOT_FOUND, 7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'h0000_0001, 1'b1, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'h8000_0001, 1'b1, ssdr_pkg::ST_NOT_FOUND, 7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'h8000_0000, 1'b1, ssdr_pkg::ST_FOUND,     7'd5},
    '{ssdr_pkg::CMD_INSERT, 32'h7FFF_FFFE, 1'b1, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'h7FFF_FFFE, 1'b1, ssdr_pkg::ST_FOUND,     7'd2},
    '{ssdr_pkg::CMD_INSERT, 32'h5555_5555, 1'b0, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b0, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'h5555_5555, 1'b0, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'hAAAA_AAAA, 1'b0, ssdr_pkg::ST_INSERTED,  7'd0},
    '{ssdr_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b1, ssdr_pkg::ST_DUPLICATE, 7'd0},
    '{ssdr_pkg::CMD_QUERY,  32'h0000_0000, 1'b0, ssdr_pkg::ST_INSERTED,  7'd0}
  };

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic                          command   = ssdr_pkg::CMD_INSERT;
  logic [VALUE_WIDTH-1:0]        value     = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ssdr_pkg::STATUS_W-1:0] status;
  logic [ssdr_pkg::RANK_W-1:0]   rank;

  // Behavioral copy of the set and the results still owed by the block.
  val_t           held_values [CAPACITY];
  int             held_count  = 0;
  ssdr_pkg::res_t pending_results [$];
  ssdr_pkg::res_t oldest;
  int             error_count = 0;
  bit             steady      = 1'b0;
  int             out_hold    = 0;

  sorted_set_descending_rank_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .rank      (rank)
  );

  always #1 clk = ~clk;

  // Applies one command to the set copy and returns the result it should give.
  function automatic ssdr_pkg::res_t apply_command(input logic cmd, input val_t v);
    ssdr_pkg::res_t r;
    bit             present;
    int             at_or_above;
    present     = 1'b0;
    at_or_above = 0;
    for (int i = 0; i < held_count; i++) begin
      if (held_values[i] == v) present = 1'b1;
      if (held_values[i] >= v) at_or_above++;
    end
    r.rank = '0;
    if (cmd == ssdr_pkg::CMD_INSERT) begin
      if (present) begin
        r.status = ssdr_pkg::ST_DUPLICATE;
      end else if (held_count >= CAPACITY) begin
        r.status = ssdr_pkg::ST_FULL;
      end else begin
        held_values[held_count] = v;
        held_count++;
        r.status = ssdr_pkg::ST_INSERTED;
      end
    end else if (present) begin
      r.status = ssdr_pkg::ST_FOUND;
      r.rank   = ssdr_pkg::RANK_W'(at_or_above);
    end else begin
      r.status = ssdr_pkg::ST_NOT_FOUND;
    end
    return r;
  endfunction

  function automatic val_t any_held();
    return held_values[$urandom_range(0, held_count - 1)];
  endfunction

  // Mix of wide random values, a crowded band around zero, the two extremes
  // and neighbors of stored values, so that ties and near misses are common.
  function automatic val_t pick_value();
    int k;
    k = $urandom_range(0, 40);
    case ($urandom_range(0, 4))
      0, 1: return val_t'($urandom());
      2: return val_t'(k - 20);
      3: begin
        if ($urandom_range(0, 1) == 1) return val_t'(32'h7FFF_FFFF - k % 4);
        return val_t'(32'h8000_0000 + k % 4);
      end
      default: begin
        if (held_count == 0) return val_t'($urandom());
        if ($urandom_range(0, 1) == 1) return any_held() + 1;
        return any_held() - 1;
      end
    endcase
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Drives one item and records its expected result once the transfer happens.
  task automatic send_item(input logic cmd, input val_t v, input bit known,
                           input ssdr_pkg::status_t st,
                           input logic [ssdr_pkg::RANK_W-1:0] rk);
    int             gap;
    ssdr_pkg::res_t predicted;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_command(cmd, v);
    if (known) begin
      predicted.status = st;
      predicted.rank   = rk;
    end
    pending_results.push_back(predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: after each transfer it may hold stall high for a while.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_hold = steady ? 0 : $urandom_range(0, 7);
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: status %0d rank %0d", status, rank));
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status)
          report_error($sformatf("status mismatch: expected %0d, got %0d",
                                 oldest.status, status));
        if (rank !== oldest.rank)
          report_error($sformatf("rank mismatch: expected %0d, got %0d",
                                 oldest.rank, rank));
      end
    end
  end

  initial begin
    int   pick;
    logic cmd;
    val_t v;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].known,
                directed_rows[i].st, directed_rows[i].rk);
    wait_drained();

    // New values arrive slowly, so queries see every fill level before the set
    // saturates; the later part runs against a full set.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n % 300 == 150) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 15 || held_count == 0) begin
        cmd = ssdr_pkg::CMD_INSERT;
        v   = pick_value();
      end else if (pick < 25) begin
        cmd = ssdr_pkg::CMD_INSERT;
        v   = any_held();
      end else if (pick < 80) begin
        cmd = ssdr_pkg::CMD_QUERY;
        v   = any_held();
      end else begin
        cmd = ssdr_pkg::CMD_QUERY;
        v   = pick_value();
      end
      send_item(cmd, v, 1'b0, ssdr_pkg::ST_INSERTED, '0);
    end

    wait_drained();
    repeat (CAPACITY + 10) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
